[design/fqd_pkg.sv]
// Shared types, widths and command/fault codes for the FIFO queue with dedup.
// No dependencies; every other design file refers to this package by scope.
package fqd_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned RMV_W   = 4;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned FAULT_W = 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [FUNC_W-1:0]        func_t;
  typedef logic [FAULT_W-1:0]       fault_t;
  typedef logic [RMV_W-1:0]         rmv_t;
  typedef logic [OCC_W-1:0]         occ_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam func_t FUNC_ENQ  = 2'd0;
  localparam func_t FUNC_DEQ  = 2'd1;
  localparam func_t FUNC_UNIQ = 2'd2;

  localparam fault_t FAULT_NONE  = 2'd0;
  localparam fault_t FAULT_EMPTY = 2'd1;
  localparam fault_t FAULT_FULL  = 2'd2;

  localparam rmv_t RMV_MAX = {RMV_W{1'b1}};

  // Per-cell control: load wins over shift.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

[design/fqd_if.sv]
// Request and response channel interfaces for the FIFO queue with dedup.
// Depends on fqd_pkg for payload types.
interface fqd_req_if;
  logic          valid;
  logic          ready;
  fqd_pkg::func_t func;
  fqd_pkg::data_t value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface fqd_rsp_if;
  logic            valid;
  logic            ready;
  fqd_pkg::data_t  out_value;
  fqd_pkg::data_t  head_value;
  fqd_pkg::rmv_t   removed_count;
  fqd_pkg::occ_t   occupancy;
  logic            is_empty;
  fqd_pkg::fault_t fault;

  modport source (output valid, output out_value, output head_value, output removed_count,
                  output occupancy, output is_empty, output fault, input ready);
  modport sink   (input valid, input out_value, input head_value, input removed_count,
                  input occupancy, input is_empty, input fault, output ready);
endinterface

[design/fqd_cell.sv]
// One storage cell of the queue chain: holds one entry, takes its right
// neighbor's entry on shift or a new entry on load. Depends on fqd_pkg.
module fqd_cell (
  input  logic              clk_i,
  input  fqd_pkg::cell_ctl_t ctl_i,
  input  fqd_pkg::data_t    load_data_i,
  input  fqd_pkg::data_t    nbr_data_i,
  output fqd_pkg::data_t    data_o
);

  fqd_pkg::data_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = load_data_i;
    end else if (ctl_i.shift) begin
      data_d = nbr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[design/fifo_queue_with_dedup.sv]
// Bounded FIFO of signed 32-bit entries held in a chain of cells, front in
// cell 0. Every request gives one response. Enqueue, dequeue and the no-op
// code are answered from the idle state; make-unique rotates the whole
// queue once through the chain, one entry per cycle, dropping later copies
// of the value as they pass the front, and then loads its response; no
// request enters until the pass is over. A registered response stage lets
// the next request enter in the same cycle that the waiting response is
// taken; while a response waits unread, no request enters.
// Depends on fqd_pkg, fqd_if and fqd_cell.
module fifo_queue_with_dedup (
  input  logic         clk_i,
  input  logic         rst_ni,
  fqd_req_if.sink      req_i,
  fqd_rsp_if.source    rsp_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UNIQ = 1'b1;

  logic              state_q, state_d;
  fqd_pkg::cnt_t     count_q, count_d;
  fqd_pkg::cnt_t     remain_q, remain_d;
  fqd_pkg::cnt_t     removed_q, removed_d;
  logic              seen_q, seen_d;
  fqd_pkg::data_t    key_q, key_d;

  fqd_pkg::data_t    cell_data [fqd_pkg::DEPTH];
  fqd_pkg::cell_ctl_t cell_ctl [fqd_pkg::DEPTH];
  logic              shift_all;
  logic              load_en;
  fqd_pkg::idx_t     load_idx;
  fqd_pkg::data_t    load_data;

  logic              accept;
  logic              rsp_load;
  logic              rsp_valid_q, rsp_valid_d;
  fqd_pkg::data_t    out_value_q, out_value_d;
  fqd_pkg::data_t    head_q, head_d;
  fqd_pkg::rmv_t     removed_out_q, removed_out_d;
  fqd_pkg::occ_t     occ_q;
  logic              empty_q;
  fqd_pkg::fault_t   fault_q, fault_d;

  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  genvar gi;
  generate
    for (gi = 0; gi < fqd_pkg::DEPTH; gi++) begin : g_cell
      fqd_pkg::data_t nbr;
      if (gi < fqd_pkg::DEPTH - 1) begin : g_mid
        assign nbr = cell_data[gi+1];
      end else begin : g_last
        assign nbr = '0;
      end
      assign cell_ctl[gi].shift = shift_all;
      assign cell_ctl[gi].load  = load_en && (load_idx == fqd_pkg::IDX_W'(gi));
      fqd_cell u_cell (
        .clk_i       (clk_i),
        .ctl_i       (cell_ctl[gi]),
        .load_data_i (load_data),
        .nbr_data_i  (nbr),
        .data_o      (cell_data[gi])
      );
    end
  endgenerate

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    remain_d      = remain_q;
    removed_d     = removed_q;
    seen_d        = seen_q;
    key_d         = key_q;
    shift_all     = 1'b0;
    load_en       = 1'b0;
    load_idx      = count_q[fqd_pkg::IDX_W-1:0];
    load_data     = req_i.value;
    rsp_load      = 1'b0;
    out_value_d   = '0;
    head_d        = (count_q != '0) ? cell_data[0] : '0;
    removed_out_d = '0;
    fault_d       = fqd_pkg::FAULT_NONE;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.func)
            fqd_pkg::FUNC_ENQ: begin
              rsp_load = 1'b1;
              if (count_q >= fqd_pkg::CNT_W'(fqd_pkg::DEPTH)) begin
                fault_d = fqd_pkg::FAULT_FULL;
              end else begin
                load_en = 1'b1;
                count_d = count_q + fqd_pkg::CNT_W'(1);
                if (count_q == '0) begin
                  head_d = req_i.value;
                end
              end
            end
            fqd_pkg::FUNC_DEQ: begin
              rsp_load = 1'b1;
              if (count_q == '0) begin
                fault_d = fqd_pkg::FAULT_EMPTY;
              end else begin
                shift_all   = 1'b1;
                out_value_d = cell_data[0];
                count_d     = count_q - fqd_pkg::CNT_W'(1);
                head_d      = (count_q > fqd_pkg::CNT_W'(1)) ? cell_data[1] : '0;
              end
            end
            fqd_pkg::FUNC_UNIQ: begin
              state_d   = ST_UNIQ;
              remain_d  = count_q;
              removed_d = '0;
              seen_d    = 1'b0;
              key_d     = req_i.value;
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end
      ST_UNIQ: begin
        if (remain_q == '0) begin
          rsp_load      = 1'b1;
          state_d       = ST_IDLE;
          removed_out_d = (removed_q > fqd_pkg::CNT_W'(fqd_pkg::RMV_MAX)) ?
                          fqd_pkg::RMV_MAX : fqd_pkg::RMV_W'(removed_q);
        end else begin
          // Front entry leaves the chain; it is re-appended at the tail
          // unless it is a later copy of the key.
          remain_d  = remain_q - fqd_pkg::CNT_W'(1);
          shift_all = 1'b1;
          if ((cell_data[0] == key_q) && seen_q) begin
            count_d   = count_q - fqd_pkg::CNT_W'(1);
            removed_d = removed_q + fqd_pkg::CNT_W'(1);
          end else begin
            load_en   = 1'b1;
            load_idx  = fqd_pkg::IDX_W'(count_q - fqd_pkg::CNT_W'(1));
            load_data = cell_data[0];
            seen_d    = seen_q || (cell_data[0] == key_q);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_d = rsp_load || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      removed_q   <= '0;
      seen_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      removed_q   <= removed_d;
      seen_q      <= seen_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (rsp_load) begin
      out_value_q   <= out_value_d;
      head_q        <= head_d;
      removed_out_q <= removed_out_d;
      occ_q         <= fqd_pkg::OCC_W'(count_d);
      empty_q       <= (count_d == '0);
      fault_q       <= fault_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.out_value     = out_value_q;
  assign rsp_o.head_value    = head_q;
  assign rsp_o.removed_count = removed_out_q;
  assign rsp_o.occupancy     = occ_q;
  assign rsp_o.is_empty      = empty_q;
  assign rsp_o.fault         = fault_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fqd_pkg::CNT_W'(fqd_pkg::DEPTH))
    else $error("queue count above depth");

  a_no_req_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UNIQ) |-> !req_i.ready)
    else $error("request taken during make-unique pass");

  a_uniq_enters_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.func == fqd_pkg::FUNC_UNIQ)) |=> (state_q == ST_UNIQ) && !rsp_valid_q)
    else $error("make-unique did not start a pass");

  a_simple_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.func != fqd_pkg::FUNC_UNIQ)) |=> rsp_valid_q)
    else $error("missing response for single-cycle request");

  a_pass_no_growth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UNIQ) |=> (count_q <= $past(count_q)))
    else $error("queue grew during make-unique pass");
`endif

endmodule
